// ===== sv/json_key_string_extractor_defines.svh =====
// ----------------------------------------------------------------------------
// JSON key string extractor: assertion macros
// Shared concurrent assertion helpers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef JSON_KEY_STRING_EXTRACTOR_DEFINES_SVH
`define JSON_KEY_STRING_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define JKSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jkse: same-cycle check failed");
// Next-cycle implication.
`define JKSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jkse: next-cycle check failed");
`else
`define JKSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define JKSE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/jkse_pkg.sv =====
// ----------------------------------------------------------------------------
// jkse_pkg
// Types, constants and helpers shared by the JSON key string extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int WIN_DEPTH     = MAX_KEY_BYTES + 2;
    localparam int KEY_LEN_W     = 5;
    localparam int KLEN_W        = $clog2(MAX_KEY_BYTES + 1);
    localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Result status codes
    localparam logic [2:0] ST_CLOSED   = 3'd0;
    localparam logic [2:0] ST_OPEN     = 3'd1;
    localparam logic [2:0] ST_NO_KEY   = 3'd2;
    localparam logic [2:0] ST_NO_COLON = 3'd3;
    localparam logic [2:0] ST_NO_QUOTE = 3'd4;

    typedef struct packed {
        logic [7:0] json_byte;
        logic       end_of_document;
    } t_in_item;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       value_end;
        logic [2:0] status;
    } t_out_item;

    // Classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       search;
        logic       match;
        logic       ws;
        logic       colon;
        logic       quote;
        logic       bslash;
    } t_token;

    // Back-end observation bundle
    typedef struct packed {
        logic take;
        logic phase_search;
        logic phase_done;
        logic push_end;
    } t_back_stat;

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LC_B: r = CH_BS;
            CH_LC_F: r = CH_FF;
            CH_LC_N: r = CH_LF;
            CH_LC_R: r = CH_CR;
            CH_LC_T: r = CH_TAB;
            default: r = c;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/json_key_string_extractor.sv =====
// ----------------------------------------------------------------------------
// json_key_string_extractor
// Pulls the string value of one configured key out of a JSON byte stream.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Beat payload
//  -------   ------------------   ----------------------------------------
//  input     push / full          t_in_item  : json_byte, end_of_document
//  result    empty / pop          t_out_item : value_byte, byte_valid,
//                                              value_end, status
//  config    i_cfg_we             i_cfg_index, i_cfg_data (64 bits)
//
//  Throughput is one byte per clock while neither queue is full: the
//  quoted-key compare over the 18-byte window is a single parallel step
//  in the front end. A result passes through the token queue, then the
//  back-end result queue, each queue two entries deep.
//  Reset is synchronous on i_rst_n; it clears the key registers, the
//  search state and both queues. No clearing pass is needed.
//  Either side may stall at will; the two queues absorb the slack. A full
//  result queue holds the back end, and full rises once two bytes wait.
//
`include "json_key_string_extractor_defines.svh"

module json_key_string_extractor
    import jkse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // document bytes in
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_in_item,
    // results out
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_out_item
);

    // Classified bytes travel from front to back through a small queue
    // inside the front end; the back end takes one whenever its own result
    // queue has room.
    logic       tok_valid;
    t_token     tok;
    logic       tok_take;
    t_back_stat stat;

    // Front: key registers, window match, byte classification
    jkse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in_item),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_take  (tok_take)
    );

    // Back: colon / quote / value sequencing and unescaping
    jkse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_take  (tok_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item),
        .o_stat      (stat)
    );

    // Front and back must agree on whether a byte belongs to the key search.
    `JKSE_ASSERT_IMP(a_search_agree, i_clk, i_rst_n, stat.take, tok.search == stat.phase_search)
    // A final result leaves the back end restarted or finished for the document.
    `JKSE_ASSERT_NXT(a_end_settles, i_clk, i_rst_n, stat.push_end, stat.phase_search || stat.phase_done)
    // Status is only carried on the final result of a document.
    `JKSE_ASSERT_IMP(a_status_final, i_clk, i_rst_n, !empty && !o_out_item.value_end, o_out_item.status == ST_CLOSED)
    // A beat without a value byte carries a zero byte.
    `JKSE_ASSERT_IMP(a_byte_zero, i_clk, i_rst_n, !empty && !o_out_item.byte_valid, o_out_item.value_byte == 8'h00)

endmodule

// ===== sv/jkse_front.sv =====
// ----------------------------------------------------------------------------
// jkse_front
// Holds the key registers, matches the quoted key over a sliding window and
// queues classified bytes for the back end.
// ----------------------------------------------------------------------------
module jkse_front
    import jkse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    output logic                  o_full,
    input  t_in_item              i_item,
    output logic                  o_tok_valid,
    output t_token                o_tok,
    input  logic                  i_tok_take
);

    logic [CFG_DATA_W-1:0]   r_key_low;
    logic [CFG_DATA_W-1:0]   r_key_high;
    logic [KEY_LEN_W-1:0]    r_key_len;

    logic [7:0]              r_win [WIN_DEPTH];
    logic [FILL_W-1:0]       r_fill;
    logic                    r_found;

    t_token                  r_q [2];
    logic                    r_wr;
    logic                    r_rd;
    logic [1:0]              r_cnt;

    logic [2*CFG_DATA_W-1:0] key_flat;
    logic [7:0]              key [MAX_KEY_BYTES];
    logic [KLEN_W-1:0]       klen;
    logic [7:0]              win_nx [WIN_DEPTH];
    logic [FILL_W-1:0]       fill_nx;
    logic [MAX_KEY_BYTES:0]  match_by_len;
    logic                    accept;
    t_token                  tok_in;

    assign accept      = i_push && !o_full;
    assign o_full      = (r_cnt == 2'd2);
    assign o_tok_valid = (r_cnt != 2'd0);
    assign o_tok       = r_q[r_rd];

    assign key_flat = {r_key_high, r_key_low};
    assign klen     = (r_key_len > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                      KLEN_W'(MAX_KEY_BYTES) : KLEN_W'(r_key_len);

    always_comb begin
        for (int j = 0; j < MAX_KEY_BYTES; j++) begin
            key[j] = key_flat[8*j +: 8];
        end
    end

    // Window after this byte, and a match check per candidate key length
    always_comb begin
        logic hit;
        win_nx[0] = i_item.json_byte;
        for (int p = 1; p < WIN_DEPTH; p++) begin
            win_nx[p] = r_win[p-1];
        end
        fill_nx = (r_fill == FILL_W'(WIN_DEPTH)) ? r_fill : r_fill + FILL_W'(1);
        for (int l = 0; l <= MAX_KEY_BYTES; l++) begin
            hit = (fill_nx >= FILL_W'(l + 2)) &&
                  (win_nx[0] == CH_QUOTE) && (win_nx[l+1] == CH_QUOTE);
            for (int j = 0; j < l; j++) begin
                hit = hit && (win_nx[l-j] == key[j]);
            end
            match_by_len[l] = hit;
        end
    end

    always_comb begin
        tok_in.data   = i_item.json_byte;
        tok_in.last   = i_item.end_of_document;
        tok_in.search = !r_found;
        tok_in.match  = !r_found && match_by_len[klen];
        tok_in.ws     = (i_item.json_byte == CH_SPACE) || (i_item.json_byte == CH_TAB) ||
                        (i_item.json_byte == CH_LF) || (i_item.json_byte == CH_CR);
        tok_in.colon  = (i_item.json_byte == CH_COLON);
        tok_in.quote  = (i_item.json_byte == CH_QUOTE);
        tok_in.bslash = (i_item.json_byte == CH_BSLASH);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                default:      ;
            endcase
        end
    end

    // Search state: fill count gates stale window bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_found <= 1'b0;
        end else if (accept) begin
            if (i_item.end_of_document) begin
                r_fill  <= '0;
                r_found <= 1'b0;
            end else if (!r_found) begin
                r_fill  <= fill_nx;
                r_found <= tok_in.match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_found) begin
            r_win <= win_nx;
        end
        if (accept) begin
            r_q[r_wr] <= tok_in;
        end
    end

    // Token queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (accept) begin
                r_wr <= ~r_wr;
            end
            if (i_tok_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, i_tok_take};
        end
    end

endmodule

// ===== sv/jkse_back.sv =====
// ----------------------------------------------------------------------------
// jkse_back
// Runs the colon / quote / value sequence on classified bytes, undoes
// escapes and queues results for the consumer.
// ----------------------------------------------------------------------------
module jkse_back
    import jkse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tok_valid,
    input  t_token     i_tok,
    output logic       o_tok_take,
    input  logic       i_pop,
    output logic       o_empty,
    output t_out_item  o_item,
    output t_back_stat o_stat
);

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_COLON  = 5'b00010,
        PH_QUOTE  = 5'b00100,
        PH_VALUE  = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    t_phase     r_phase;
    t_phase     n_phase;
    logic       r_esc;
    logic       n_esc;

    t_out_item  r_rq [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    logic       take;
    logic       emit;
    t_out_item  res;
    logic       pop_acc;
    logic       push;

    assign take       = i_tok_valid && (r_cnt != 2'd2);
    assign o_tok_take = take;
    assign push       = take && emit;
    assign pop_acc    = i_pop && (r_cnt != 2'd0);
    assign o_empty    = (r_cnt == 2'd0);
    assign o_item     = r_rq[r_rd];

    assign o_stat.take         = take;
    assign o_stat.phase_search = (r_phase == PH_SEARCH);
    assign o_stat.phase_done   = (r_phase == PH_DONE);
    assign o_stat.push_end     = push && res.value_end;

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        emit    = 1'b0;
        res     = '0;
        if (take) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    if (i_tok.match) begin
                        n_phase = PH_COLON;
                        if (i_tok.last) begin
                            emit = 1'b1;
                            res.value_end = 1'b1;
                            res.status    = ST_NO_COLON;
                        end
                    end else if (i_tok.last) begin
                        emit = 1'b1;
                        res.value_end = 1'b1;
                        res.status    = ST_NO_KEY;
                    end
                end
                PH_COLON: begin
                    if (i_tok.colon) begin
                        n_phase = PH_QUOTE;
                        if (i_tok.last) begin
                            emit = 1'b1;
                            res.value_end = 1'b1;
                            res.status    = ST_NO_QUOTE;
                        end
                    end else if (!i_tok.ws || i_tok.last) begin
                        emit = 1'b1;
                        res.value_end = 1'b1;
                        res.status    = ST_NO_COLON;
                        n_phase       = PH_DONE;
                    end
                end
                PH_QUOTE: begin
                    if (i_tok.quote) begin
                        n_phase = PH_VALUE;
                        if (i_tok.last) begin
                            emit = 1'b1;
                            res.value_end = 1'b1;
                            res.status    = ST_OPEN;
                        end
                    end else if (!i_tok.ws || i_tok.last) begin
                        emit = 1'b1;
                        res.value_end = 1'b1;
                        res.status    = ST_NO_QUOTE;
                        n_phase       = PH_DONE;
                    end
                end
                PH_VALUE: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        emit  = 1'b1;
                        res.value_byte = unescape(i_tok.data);
                        res.byte_valid = 1'b1;
                        res.value_end  = i_tok.last;
                        res.status     = i_tok.last ? ST_OPEN : ST_CLOSED;
                    end else if (i_tok.quote) begin
                        emit = 1'b1;
                        res.value_end = 1'b1;
                        res.status    = ST_CLOSED;
                        n_phase       = PH_DONE;
                    end else if (i_tok.bslash && !i_tok.last) begin
                        n_esc = 1'b1;
                    end else begin
                        emit = 1'b1;
                        res.value_byte = i_tok.data;
                        res.byte_valid = 1'b1;
                        res.value_end  = i_tok.last;
                        res.status     = i_tok.last ? ST_OPEN : ST_CLOSED;
                    end
                end
                PH_DONE: ;
                default: n_phase = PH_SEARCH;
            endcase
            // restart on the last byte of a document
            if (i_tok.last) begin
                n_phase = PH_SEARCH;
                n_esc   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEARCH;
            r_esc   <= 1'b0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop_acc) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_rq[r_wr] <= res;
        end
    end

endmodule
